// ----- design/rcmd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths, register codes and reset values for the RC channel mode decoder.
package rcmd_pkg;

  localparam int PwmW   = 12;
  localparam int DzW    = 9;
  localparam int GainW  = 32;
  localparam int StickW = 16;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam logic [PwmW-1:0] StickCenterUs = 12'd1500;
  localparam logic [PwmW-1:0] ValidMaxUs    = 12'd2100;

  localparam logic [DzW-1:0]   DeadZoneRst  = 9'd125;
  localparam logic [GainW-1:0] GainRst      = 32'd5726623;
  localparam logic [PwmW-1:0]  ModeThrRst   = 12'd1750;
  localparam logic [PwmW-1:0]  GearThrRst   = 12'd1750;
  localparam logic [PwmW-1:0]  RebootThrRst = 12'd1500;

  typedef logic [PwmW-1:0]          pwm_t;
  typedef logic signed [StickW-1:0] stick_t;

  typedef enum logic [2:0] {
    REG_DZ_US      = 3'd0,
    REG_GAIN       = 3'd1,
    REG_MODE_THR   = 3'd2,
    REG_GEAR_THR   = 3'd3,
    REG_REBOOT_THR = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DzW-1:0]   dz_us;
    logic [GainW-1:0] gain;
  } stick_cfg_t;

endpackage

// ----- design/rc_channel_mode_decoder.sv -----
`timescale 1ns / 1ps
// RC channel mode decoder: each input beat passes an input register, then an output
// register. Throughput one beat per cycle while out_stall is low; the input register
// feeds stick scaling and switch edge logic, whose results land in the output register,
// which holds under out_stall. Synchronous active-low reset empties both stages,
// restores register defaults, clears switch history and sets command mode.
module rc_channel_mode_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rcmd_pkg::pwm_t            in_pwm_ch0,
  input  rcmd_pkg::pwm_t            in_pwm_ch1,
  input  rcmd_pkg::pwm_t            in_pwm_ch2,
  input  rcmd_pkg::pwm_t            in_pwm_ch3,
  input  rcmd_pkg::pwm_t            in_pwm_mode,
  input  rcmd_pkg::pwm_t            in_pwm_gear,
  input  rcmd_pkg::pwm_t            in_pwm_reboot,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rcmd_pkg::stick_t          out_stick_0,
  output rcmd_pkg::stick_t          out_stick_1,
  output rcmd_pkg::stick_t          out_stick_2,
  output rcmd_pkg::stick_t          out_stick_3,
  output logic                      out_hover_mode,
  output logic                      out_enter_hover,
  output logic                      out_command_mode,
  output logic                      out_enter_command,
  output logic                      out_reboot_toggle,
  output logic                      out_sticks_centered,
  output logic                      out_data_valid,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rcmd_pkg::AddrW-1:0] paddr,
  input  logic [rcmd_pkg::DataW-1:0] pwdata,
  output logic [rcmd_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import rcmd_pkg::*;

  // configuration registers
  logic [DzW-1:0]   dz_us_r;
  logic [GainW-1:0] gain_r;
  pwm_t             mode_thr_r;
  pwm_t             gear_thr_r;
  pwm_t             reboot_thr_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  stick_cfg_t       stick_cfg;

  // input stage
  logic s1_valid_r;
  pwm_t s1_ch_r [4];
  pwm_t s1_mode_r;
  pwm_t s1_gear_r;
  pwm_t s1_reboot_r;
  logic s1_load;
  logic advance;

  // switch history
  pwm_t prev_mode_r;
  pwm_t prev_gear_r;
  pwm_t prev_reboot_r;
  logic primed_r;
  logic cmd_r;
  logic ent_cmd_r;
  logic cmd_nxt;
  logic ent_cmd_nxt;

  pwm_t   prev_mode;
  pwm_t   prev_gear;
  pwm_t   prev_reboot;
  logic   hover;
  logic   ent_hover;
  logic   gear_rise;
  logic   reboot_rise;
  logic   toggle;
  logic   centered;
  logic   data_ok;
  stick_t stick [4];

  // output stage
  logic   out_valid_r;
  stick_t out_stick_r [4];
  logic   out_hover_r;
  logic   out_ent_hover_r;
  logic   out_cmd_r;
  logic   out_ent_cmd_r;
  logic   out_toggle_r;
  logic   out_centered_r;
  logic   out_data_ok_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_us_r      <= DeadZoneRst;
      gain_r       <= GainRst;
      mode_thr_r   <= ModeThrRst;
      gear_thr_r   <= GearThrRst;
      reboot_thr_r <= RebootThrRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DZ_US:      dz_us_r      <= pwdata[DzW-1:0];
        REG_GAIN:       gain_r       <= pwdata[GainW-1:0];
        REG_MODE_THR:   mode_thr_r   <= pwdata[PwmW-1:0];
        REG_GEAR_THR:   gear_thr_r   <= pwdata[PwmW-1:0];
        REG_REBOOT_THR: reboot_thr_r <= pwdata[PwmW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DZ_US:      prdata = {{(DataW-DzW){1'b0}}, dz_us_r};
      REG_GAIN:       prdata = gain_r;
      REG_MODE_THR:   prdata = {{(DataW-PwmW){1'b0}}, mode_thr_r};
      REG_GEAR_THR:   prdata = {{(DataW-PwmW){1'b0}}, gear_thr_r};
      REG_REBOOT_THR: prdata = {{(DataW-PwmW){1'b0}}, reboot_thr_r};
      default:        prdata = '0;
    endcase
  end

  // pipeline flow
  assign advance  = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || advance;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_ch_r[0]  <= in_pwm_ch0;
      s1_ch_r[1]  <= in_pwm_ch1;
      s1_ch_r[2]  <= in_pwm_ch2;
      s1_ch_r[3]  <= in_pwm_ch3;
      s1_mode_r   <= in_pwm_mode;
      s1_gear_r   <= in_pwm_gear;
      s1_reboot_r <= in_pwm_reboot;
    end
  end

  assign stick_cfg.dz_us = dz_us_r;
  assign stick_cfg.gain  = gain_r;

  for (genvar g = 0; g < 4; g++) begin : g_stick
    rcmd_stick u_stick (
      .pwm   (s1_ch_r[g]),
      .cfg   (stick_cfg),
      .stick (stick[g])
    );
  end

  always_comb begin
    prev_mode   = primed_r ? prev_mode_r   : s1_mode_r;
    prev_gear   = primed_r ? prev_gear_r   : s1_gear_r;
    prev_reboot = primed_r ? prev_reboot_r : s1_reboot_r;
    hover       = s1_mode_r > mode_thr_r;
    ent_hover   = (prev_mode < mode_thr_r) && hover;
    gear_rise   = (prev_gear < gear_thr_r) && (s1_gear_r > gear_thr_r);
    reboot_rise = (prev_reboot < reboot_thr_r) && (s1_reboot_r > reboot_thr_r);
    cmd_nxt     = cmd_r;
    ent_cmd_nxt = ent_cmd_r;
    if (hover) begin
      cmd_nxt = s1_gear_r > gear_thr_r;
      if (gear_rise) begin
        ent_cmd_nxt = 1'b1;
      end else if (s1_gear_r < gear_thr_r) begin
        ent_cmd_nxt = 1'b0;
      end
    end
    toggle   = !hover && !cmd_nxt && reboot_rise;
    centered = (stick[0] == '0) && (stick[1] == '0) && (stick[2] == '0) && (stick[3] == '0);
    data_ok  = (s1_mode_r <= ValidMaxUs) && (s1_gear_r <= ValidMaxUs) &&
               (s1_reboot_r <= ValidMaxUs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      primed_r    <= 1'b0;
      cmd_r       <= 1'b1;
      ent_cmd_r   <= 1'b0;
      prev_mode_r   <= '0;
      prev_gear_r   <= '0;
      prev_reboot_r <= '0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        primed_r      <= 1'b1;
        cmd_r         <= cmd_nxt;
        ent_cmd_r     <= ent_cmd_nxt;
        prev_mode_r   <= s1_mode_r;
        prev_gear_r   <= s1_gear_r;
        prev_reboot_r <= s1_reboot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_stick_r     <= stick;
      out_hover_r     <= hover;
      out_ent_hover_r <= ent_hover;
      out_cmd_r       <= cmd_nxt;
      out_ent_cmd_r   <= ent_cmd_nxt;
      out_toggle_r    <= toggle;
      out_centered_r  <= centered;
      out_data_ok_r   <= data_ok;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_stick_0         = out_stick_r[0];
  assign out_stick_1         = out_stick_r[1];
  assign out_stick_2         = out_stick_r[2];
  assign out_stick_3         = out_stick_r[3];
  assign out_hover_mode      = out_hover_r;
  assign out_enter_hover     = out_ent_hover_r;
  assign out_command_mode    = out_cmd_r;
  assign out_enter_command   = out_ent_cmd_r;
  assign out_reboot_toggle   = out_toggle_r;
  assign out_sticks_centered = out_centered_r;
  assign out_data_valid      = out_data_ok_r;

  a_centered_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sticks_centered == ((out_stick_0 == '0) && (out_stick_1 == '0) &&
                                           (out_stick_2 == '0) && (out_stick_3 == '0))))
    else $error("centered flag disagrees with stick values");

  a_toggle_outside_modes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reboot_toggle |-> !out_hover_mode && !out_command_mode)
    else $error("reboot edge reported inside hover or command mode");

  a_enter_hover_in_hover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_enter_hover |-> out_hover_mode)
    else $error("hover entry without hover mode");

  a_stick_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_stick_0 != 16'sh8000) && (out_stick_1 != 16'sh8000) &&
                  (out_stick_2 != 16'sh8000) && (out_stick_3 != 16'sh8000))
    else $error("stick magnitude escaped saturation");

  a_history_update: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_valid_r |=> primed_r && (prev_mode_r == $past(s1_mode_r)))
    else $error("switch history not updated on advance");

endmodule

// ----- design/rcmd_stick.sv -----
`timescale 1ns / 1ps
// One stick channel: center offset, dead zone, gain scaling and Q1.15 saturation.
module rcmd_stick (
  input  rcmd_pkg::pwm_t       pwm,
  input  rcmd_pkg::stick_cfg_t cfg,
  output rcmd_pkg::stick_t     stick
);
  import rcmd_pkg::*;

  logic signed [PwmW:0]       off;
  logic signed [PwmW:0]       dz_s;
  logic signed [PwmW:0]       diff_pos;
  logic signed [PwmW:0]       diff_neg;
  logic                       pos;
  logic                       neg;
  logic [PwmW-1:0]            excess;
  logic [PwmW+GainW-1:0]      prod;
  logic [PwmW+GainW-17:0]     scaled;
  logic [StickW-2:0]          mag;
  logic [StickW-1:0]          mag_ext;

  always_comb begin
    off      = $signed({1'b0, pwm}) - $signed({1'b0, StickCenterUs});
    dz_s     = $signed({{(PwmW+1-DzW){1'b0}}, cfg.dz_us});
    diff_pos = off - dz_s;
    diff_neg = -off - dz_s;
    pos      = off > dz_s;
    neg      = off < -dz_s;
    if (pos) begin
      excess = diff_pos[PwmW-1:0];
    end else if (neg) begin
      excess = diff_neg[PwmW-1:0];
    end else begin
      excess = '0;
    end
    prod   = {{GainW{1'b0}}, excess} * {{PwmW{1'b0}}, cfg.gain};
    scaled = prod[PwmW+GainW-1:16];
    // saturate magnitude at 32767
    if (|scaled[PwmW+GainW-17:StickW-1]) begin
      mag = '1;
    end else begin
      mag = scaled[StickW-2:0];
    end
    mag_ext = {1'b0, mag};
    if (pos) begin
      stick = $signed(mag_ext);
    end else if (neg) begin
      stick = $signed(-mag_ext);
    end else begin
      stick = '0;
    end
  end

endmodule

// ----- tb/rc_channel_mode_decoder_checker.sv -----
`timescale 1ns / 1ps
// Checker for the RC channel mode decoder: predicts each result beat and compares it.
module rc_channel_mode_decoder_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  rcmd_pkg::pwm_t             in_pwm_ch0,
  input  rcmd_pkg::pwm_t             in_pwm_ch1,
  input  rcmd_pkg::pwm_t             in_pwm_ch2,
  input  rcmd_pkg::pwm_t             in_pwm_ch3,
  input  rcmd_pkg::pwm_t             in_pwm_mode,
  input  rcmd_pkg::pwm_t             in_pwm_gear,
  input  rcmd_pkg::pwm_t             in_pwm_reboot,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  rcmd_pkg::stick_t           out_stick_0,
  input  rcmd_pkg::stick_t           out_stick_1,
  input  rcmd_pkg::stick_t           out_stick_2,
  input  rcmd_pkg::stick_t           out_stick_3,
  input  logic                       out_hover_mode,
  input  logic                       out_enter_hover,
  input  logic                       out_command_mode,
  input  logic                       out_enter_command,
  input  logic                       out_reboot_toggle,
  input  logic                       out_sticks_centered,
  input  logic                       out_data_valid,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcmd_pkg::AddrW-1:0] paddr,
  input  logic [rcmd_pkg::DataW-1:0] pwdata,
  input  logic                       pready,
  output int                         mismatches,
  output int                         pending
);
  import rcmd_pkg::*;

  typedef struct packed {
    stick_t s0;
    stick_t s1;
    stick_t s2;
    stick_t s3;
    logic   hover;
    logic   enter_hover;
    logic   command;
    logic   enter_command;
    logic   toggle;
    logic   centered;
    logic   valid;
  } rc_frame_t;

  logic [DzW-1:0]   dz_cfg;
  logic [GainW-1:0] gain_cfg;
  pwm_t             mode_thr;
  pwm_t             gear_thr;
  pwm_t             reboot_thr;

  pwm_t prev_mode;
  pwm_t prev_gear;
  pwm_t prev_reboot;
  logic primed;
  logic cmd_flag;
  logic enter_cmd_flag;

  rc_frame_t predicted_frames[$];
  rc_frame_t seen;
  rc_frame_t want;
  int        result_no = 0;

  function automatic logic [15:0] q15_mag(int excess, logic [GainW-1:0] gain);
    logic [63:0] prod;
    prod = (64'(excess) * 64'(gain)) >> 16;
    return (prod > 64'd32767) ? 16'd32767 : prod[15:0];
  endfunction

  function automatic stick_t stick_q15(pwm_t pwm, logic [DzW-1:0] dz, logic [GainW-1:0] gain);
    int          off;
    int          lim;
    logic [15:0] mag;
    off = int'(pwm) - int'(StickCenterUs);
    lim = int'(dz);
    if (off > lim) return stick_t'(q15_mag(off - lim, gain));
    if (off < -lim) begin
      mag = q15_mag(-off - lim, gain);
      return stick_t'(16'd0 - mag);
    end
    return '0;
  endfunction

  function automatic logic crosses_up(pwm_t prev, pwm_t cur, pwm_t thr);
    return (prev < thr) && (cur > thr);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int seen_v, int want_v);
    if (seen_v !== want_v)
      report_mismatch($sformatf("result %0d %s: got %0d expected %0d",
                                result_no, name, seen_v, want_v));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dz_cfg         = DeadZoneRst;
      gain_cfg       = GainRst;
      mode_thr       = ModeThrRst;
      gear_thr       = GearThrRst;
      reboot_thr     = RebootThrRst;
      prev_mode      = '0;
      prev_gear      = '0;
      prev_reboot    = '0;
      primed         = 1'b0;
      cmd_flag       = 1'b1;
      enter_cmd_flag = 1'b0;
      predicted_frames.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[AddrW-1:2]))
          REG_DZ_US:      dz_cfg     = pwdata[DzW-1:0];
          REG_GAIN:       gain_cfg   = pwdata[GainW-1:0];
          REG_MODE_THR:   mode_thr   = pwdata[PwmW-1:0];
          REG_GEAR_THR:   gear_thr   = pwdata[PwmW-1:0];
          REG_REBOOT_THR: reboot_thr = pwdata[PwmW-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        seen.s0            = out_stick_0;
        seen.s1            = out_stick_1;
        seen.s2            = out_stick_2;
        seen.s3            = out_stick_3;
        seen.hover         = out_hover_mode;
        seen.enter_hover   = out_enter_hover;
        seen.command       = out_command_mode;
        seen.enter_command = out_enter_command;
        seen.toggle        = out_reboot_toggle;
        seen.centered      = out_sticks_centered;
        seen.valid         = out_data_valid;
        if (predicted_frames.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_no));
        end else begin
          want = predicted_frames.pop_front();
          check_field("stick_0", int'(seen.s0), int'(want.s0));
          check_field("stick_1", int'(seen.s1), int'(want.s1));
          check_field("stick_2", int'(seen.s2), int'(want.s2));
          check_field("stick_3", int'(seen.s3), int'(want.s3));
          check_field("hover_mode", int'(seen.hover), int'(want.hover));
          check_field("enter_hover", int'(seen.enter_hover), int'(want.enter_hover));
          check_field("command_mode", int'(seen.command), int'(want.command));
          check_field("enter_command", int'(seen.enter_command), int'(want.enter_command));
          check_field("reboot_toggle", int'(seen.toggle), int'(want.toggle));
          check_field("sticks_centered", int'(seen.centered), int'(want.centered));
          check_field("data_valid", int'(seen.valid), int'(want.valid));
        end
        result_no++;
      end

      if (in_valid && !in_stall) begin
        want.s0    = stick_q15(in_pwm_ch0, dz_cfg, gain_cfg);
        want.s1    = stick_q15(in_pwm_ch1, dz_cfg, gain_cfg);
        want.s2    = stick_q15(in_pwm_ch2, dz_cfg, gain_cfg);
        want.s3    = stick_q15(in_pwm_ch3, dz_cfg, gain_cfg);
        want.valid = (in_pwm_mode <= ValidMaxUs) && (in_pwm_gear <= ValidMaxUs) &&
                     (in_pwm_reboot <= ValidMaxUs);
        if (!primed) begin
          primed      = 1'b1;
          prev_mode   = in_pwm_mode;
          prev_gear   = in_pwm_gear;
          prev_reboot = in_pwm_reboot;
        end
        want.enter_hover = crosses_up(prev_mode, in_pwm_mode, mode_thr);
        want.hover       = in_pwm_mode > mode_thr;
        if (want.hover) begin
          if (crosses_up(prev_gear, in_pwm_gear, gear_thr)) enter_cmd_flag = 1'b1;
          else if (in_pwm_gear < gear_thr) enter_cmd_flag = 1'b0;
          cmd_flag = in_pwm_gear > gear_thr;
        end
        want.toggle = !want.hover && !cmd_flag &&
                      crosses_up(prev_reboot, in_pwm_reboot, reboot_thr);
        prev_mode          = in_pwm_mode;
        prev_gear          = in_pwm_gear;
        prev_reboot        = in_pwm_reboot;
        want.command       = cmd_flag;
        want.enter_command = enter_cmd_flag;
        want.centered      = (want.s0 == 0) && (want.s1 == 0) && (want.s2 == 0) &&
                             (want.s3 == 0);
        predicted_frames.push_back(want);
      end
    end
    pending <= predicted_frames.size();
  end

endmodule

// ----- tb/rc_channel_mode_decoder_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the RC channel mode decoder: clock, reset, stimulus and verdict.
module rc_channel_mode_decoder_tb;
  import rcmd_pkg::*;

  localparam int SegItems   = 125;
  localparam int Segments   = 9;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 400000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  pwm_t             in_pwm_ch0    = '0;
  pwm_t             in_pwm_ch1    = '0;
  pwm_t             in_pwm_ch2    = '0;
  pwm_t             in_pwm_ch3    = '0;
  pwm_t             in_pwm_mode   = '0;
  pwm_t             in_pwm_gear   = '0;
  pwm_t             in_pwm_reboot = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  stick_t           out_stick_0;
  stick_t           out_stick_1;
  stick_t           out_stick_2;
  stick_t           out_stick_3;
  logic             out_hover_mode;
  logic             out_enter_hover;
  logic             out_command_mode;
  logic             out_enter_command;
  logic             out_reboot_toggle;
  logic             out_sticks_centered;
  logic             out_data_valid;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  int mismatches;
  int pending;

  int tx_idle   = 31;
  int rx_idle   = 79;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  int cur_dz   = int'(DeadZoneRst);
  int cur_mthr = int'(ModeThrRst);
  int cur_gthr = int'(GearThrRst);
  int cur_rthr = int'(RebootThrRst);

  rc_channel_mode_decoder i_dut (.*);

  rc_channel_mode_decoder_checker i_checker (.*);

  always #5 clk = ~clk;

  function automatic pwm_t clamp_pwm(int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return pwm_t'(v);
  endfunction

  function automatic pwm_t stick_pick(int dz);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 1500 - dz - 2 + $urandom_range(0, 2 * dz + 4);
      4:          v = 1500 + dz + $urandom_range(0, 600);
      5:          v = 1500 - dz - $urandom_range(0, 600);
      6, 7:       v = $urandom_range(0, 4095);
      8:          v = $urandom_range(0, 1) ? 4095 : 0;
      default:    v = 1500;
    endcase
    return clamp_pwm(v);
  endfunction

  function automatic pwm_t switch_pick(int thr);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = thr - $urandom_range(0, 3);
      3:       v = thr;
      4, 5, 6: v = thr + $urandom_range(1, 3);
      7:       v = $urandom_range(0, 4095);
      8:       v = $urandom_range(0, 1) ? 4095 : 0;
      default: v = $urandom_range(0, 1) ? thr + $urandom_range(100, 500)
                                        : thr - $urandom_range(100, 500);
    endcase
    return clamp_pwm(v);
  endfunction

  task automatic send_frame(pwm_t c0, pwm_t c1, pwm_t c2, pwm_t c3,
                            pwm_t m, pwm_t g, pwm_t r);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pwm_ch0    <= c0;
    in_pwm_ch1    <= c1;
    in_pwm_ch2    <= c2;
    in_pwm_ch3    <= c3;
    in_pwm_mode   <= m;
    in_pwm_gear   <= g;
    in_pwm_reboot <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write_all(int dz, logic [DataW-1:0] gain, int mthr, int gthr, int rthr);
    reg_idx_t         regs [5];
    logic [DataW-1:0] vals [5];
    regs = '{REG_DZ_US, REG_GAIN, REG_MODE_THR, REG_GEAR_THR, REG_REBOOT_THR};
    vals = '{DataW'(dz), gain, DataW'(mthr), DataW'(gthr), DataW'(rthr)};
    for (int i = 0; i < 5; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {regs[i], 2'b00};
      pwdata  <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_dz   = dz;
    cur_mthr = mthr;
    cur_gthr = gthr;
    cur_rthr = rthr;
  endtask

  // receiver: random stall, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rc_channel_mode_decoder_tb: done, errors");
    $finish;
  end

  initial begin
    int          dz;
    logic [31:0] gain;
    int          mthr;
    int          gthr;
    int          rthr;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(1500, 1500, 1500, 1500, 2000, 2000, 2000);
    send_frame(1625, 1375, 1626, 1374, 2000, 1000, 1000);
    send_frame(0, 4095, 0, 4095, 1000, 1000, 1000);
    send_frame(1500, 1500, 1500, 1500, 1000, 1000, 2000);
    send_frame(1500, 1500, 1500, 1500, 1000, 1000, 1500);
    send_frame(1500, 1500, 1500, 1500, 1000, 1000, 1501);
    send_frame(1600, 1400, 1700, 1300, 1000, 1000, 0);
    send_frame(1500, 1500, 1500, 1500, 1750, 1000, 1000);
    send_frame(1500, 1500, 1500, 1500, 1751, 1000, 1000);
    send_frame(1500, 1500, 1500, 1500, 1000, 1000, 1000);
    send_frame(1500, 1500, 1500, 1500, 1751, 1000, 1000);
    send_frame(1500, 1500, 1500, 1500, 2000, 2000, 1000);
    send_frame(1500, 1500, 1500, 1500, 2000, 1750, 1000);
    send_frame(1500, 1500, 1500, 1500, 2000, 1000, 1000);
    send_frame(1500, 1500, 1500, 1500, 1000, 2000, 1000);
    send_frame(1500, 1500, 1500, 1500, 2101, 2100, 4095);
    send_frame(4095, 0, 4095, 0, 0, 4095, 2100);
    send_frame(1626, 1500, 1500, 1500, 4095, 0, 0);
    send_frame(2000, 1000, 1800, 1200, 1000, 1000, 1000);
    send_frame(1500, 1500, 1500, 1500, 1000, 1000, 2000);
    drain();

    for (int seg = 0; seg < Segments; seg++) begin
      case (seg / 3)
        0: begin tx_idle <= 31; rx_idle <= 79; end
        1: begin tx_idle <= 79; rx_idle <= 31; end
        default: begin tx_idle <= 0; rx_idle <= 0; end
      endcase
      case (seg)
        0: begin dz = 0;   gain = 32'd0;         mthr = 0;    gthr = 0;    rthr = 0;    end
        1: begin dz = 499; gain = 32'h8000_0000; mthr = 4095; gthr = 4095; rthr = 4095; end
        3: begin
          dz   = 500;
          gain = $urandom_range(0, 32'h8000_0000);
          mthr = $urandom_range(1000, 2000);
          gthr = $urandom_range(1000, 2000);
          rthr = $urandom_range(1000, 2000);
        end
        4: begin
          dz   = 511;
          gain = 32'h8000_0000;
          mthr = $urandom_range(1000, 2000);
          gthr = $urandom_range(1000, 2000);
          rthr = $urandom_range(1000, 2000);
        end
        6: begin
          dz = int'(DeadZoneRst); gain = GainRst;
          mthr = int'(ModeThrRst); gthr = int'(GearThrRst); rthr = int'(RebootThrRst);
        end
        7: begin
          dz   = $urandom_range(0, 511);
          gain = $urandom_range(0, 32'h8000_0000);
          mthr = $urandom_range(0, 4095);
          gthr = $urandom_range(0, 4095);
          rthr = $urandom_range(0, 4095);
        end
        8: begin dz = 0; gain = 32'h8000_0000; mthr = 2100; gthr = 1; rthr = 4094; end
        default: begin
          dz   = $urandom_range(0, 499);
          gain = 32'((64'h8000_0000 + 64'((500 - dz) / 2)) / 64'(500 - dz));
          mthr = $urandom_range(1000, 2000);
          gthr = $urandom_range(1000, 2000);
          rthr = $urandom_range(1000, 2000);
        end
      endcase
      cfg_write_all(dz, gain, mthr, gthr, rthr);
      if (seg == 4 || seg == 7) hold_reqs++;
      for (int n = 0; n < SegItems; n++)
        send_frame(stick_pick(cur_dz), stick_pick(cur_dz), stick_pick(cur_dz),
                   stick_pick(cur_dz), switch_pick(cur_mthr), switch_pick(cur_gthr),
                   switch_pick(cur_rthr));
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("rc_channel_mode_decoder_tb: done, clean");
    end else begin
      $display("rc_channel_mode_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/rcmd_pkg.sv
design/rcmd_stick.sv
design/rc_channel_mode_decoder.sv
tb/rc_channel_mode_decoder_checker.sv
tb/rc_channel_mode_decoder_tb.sv
